// File: hw/rtl/arpc_pkg.sv
// Shared types and constants for the ARP cache lookup/update block.
// Used by arpc_ctrl, arpc_dp and arp_cache_lookup_update; no dependencies.
package arpc_pkg;

  localparam int unsigned IP_W  = 32;
  localparam int unsigned MAC_W = 48;

  // Item kind carried on the input tuser bit
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_COMPACT,
    ST_SHIFT,
    ST_APPEND,
    ST_RESULT
  } arpc_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;         // capture item, restart scan over valid entries
    logic step_lookup;  // issue next read, compare against key
    logic step_copy;    // issue next read, write kept entries back
    logic keep_all;     // copy without dropping key matches
    logic start_shift;  // restart scan at slot 1 to drop the oldest entry
    logic append;       // write the new pair at the newest end
    logic post_result;  // move the result into the output register
  } arpc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic match;      // read data holds the key
    logic scan_done;  // no read pending and none left to issue
    logic full;       // compacted list still fills the table
    logic out_free;   // output register can take a result this cycle
  } arpc_sts_t;

endpackage

// File: hw/rtl/arp_cache_lookup_update.sv
// Top level of the ARP cache: stream ports, controller and datapath.
// Depends on arpc_pkg, arpc_ctrl and arpc_dp.
//
//  channel | dir | handshake                    | payload
//  --------+-----+------------------------------+--------------------------------
//  s_axis  | in  | s_axis_tvalid/s_axis_tready  | tuser: kind; tdata: ip, mac
//  m_axis  | out | m_axis_tvalid/m_axis_tready  | tdata: hit, found_mac,
//          |     |                              |   send_request, replaced, evicted
//
// One item at a time; the single read port of the entry memory sets the pace,
// one entry per cycle. A lookup scans up to the N valid entries before its
// result goes to the result register, stopping early on a hit. An update
// compacts the N entries and appends, with a shift pass when the full table
// drops its oldest entry. Reset clears the entry count and control state;
// entry contents are not cleared. A stalled result waits in the output register
// while the next item is accepted and processed up to its own result.
module arp_cache_lookup_update
  import arpc_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // [31:0] ip_address, [79:32] mac_address
  input  logic        s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // [0] hit, [48:1] found_mac,
                                      // [49] send_request, [50] replaced,
                                      // [51] evicted, [55:52] zero
);

  arpc_cmd_t        cmd;
  arpc_sts_t        sts;
  logic             hit;
  logic [MAC_W-1:0] found_mac;
  logic             send_request;
  logic             replaced;
  logic             evicted;

  arpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  arpc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .in_ip_i            (s_axis_tdata[IP_W-1:0]),
    .in_mac_i           (s_axis_tdata[IP_W+MAC_W-1:IP_W]),
    .in_kind_i          (s_axis_tuser),
    .out_ready_i        (m_axis_tready),
    .out_valid_o        (m_axis_tvalid),
    .out_hit_o          (hit),
    .out_found_mac_o    (found_mac),
    .out_send_request_o (send_request),
    .out_replaced_o     (replaced),
    .out_evicted_o      (evicted)
  );

  // Pack the result fields from the lowest bit up
  assign m_axis_tdata = {4'b0000, evicted, replaced, send_request, found_mac, hit};

endmodule

// File: hw/rtl/arpc_ctrl.sv
// Controller state machine of the ARP cache: sequences scan, compaction,
// shift and append passes. Depends on arpc_pkg.
module arpc_ctrl
  import arpc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_kind_i,
  output logic      in_ready_o,
  input  arpc_sts_t sts_i,
  output arpc_cmd_t cmd_o
);

  arpc_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (in_kind_i == KIND_UPDATE) ? ST_COMPACT : ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.step_lookup = 1'b1;
        if (sts_i.match || sts_i.scan_done) begin
          state_d = ST_RESULT;
        end
      end
      ST_COMPACT: begin
        cmd_o.step_copy = 1'b1;
        if (sts_i.scan_done) begin
          if (sts_i.full) begin
            cmd_o.start_shift = 1'b1;
            state_d           = ST_SHIFT;
          end else begin
            state_d = ST_APPEND;
          end
        end
      end
      ST_SHIFT: begin
        cmd_o.step_copy = 1'b1;
        cmd_o.keep_all  = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_APPEND;
        end
      end
      ST_APPEND: begin
        cmd_o.append = 1'b1;
        state_d      = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.post_result = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/arpc_dp.sv
// Datapath of the ARP cache: entry memory, scan and write pointers, entry
// count, item registers and the output register. Depends on arpc_pkg.
module arpc_dp
  import arpc_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  arpc_cmd_t        cmd_i,
  output arpc_sts_t        sts_o,
  input  logic [IP_W-1:0]  in_ip_i,
  input  logic [MAC_W-1:0] in_mac_i,
  input  logic             in_kind_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic             out_hit_o,
  output logic [MAC_W-1:0] out_found_mac_o,
  output logic             out_send_request_o,
  output logic             out_replaced_o,
  output logic             out_evicted_o
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = IP_W + MAC_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // Entry memory: ip in the low bits, mac above
  logic [EW-1:0] mem_q [TABLE_DEPTH];

  logic             kind_q;
  logic [IP_W-1:0]  ip_q;
  logic [MAC_W-1:0] mac_q;
  logic [CW-1:0]    rd_idx_q, wr_idx_q, lim_q, count_q;
  logic             pend_q;
  logic [EW-1:0]    rdata_q;
  logic             hit_q, replaced_q, evicted_q;
  logic [MAC_W-1:0] hmac_q;
  logic             out_valid_q;
  logic             out_hit_q, out_send_q, out_repl_q, out_evict_q;
  logic [MAC_W-1:0] out_mac_q;

  logic          issue;
  logic          key_eq;
  logic          copy_wr;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;

  assign issue   = (cmd_i.step_lookup || cmd_i.step_copy) && (rd_idx_q < lim_q);
  assign key_eq  = (rdata_q[IP_W-1:0] == ip_q);
  assign copy_wr = cmd_i.step_copy && pend_q && (cmd_i.keep_all || !key_eq);

  // Select the memory write: kept entry during a copy pass, new pair on append
  always_comb begin
    mem_we = copy_wr || cmd_i.append;
    mem_wa = wr_idx_q[IW-1:0];
    mem_wd = cmd_i.append ? {mac_q, ip_q} : rdata_q;
  end

  // Write and registered read of the entry memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (issue) begin
      rdata_q <= mem_q[rd_idx_q[IW-1:0]];
    end
  end

  // Capture the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= in_kind_i;
      ip_q   <= in_ip_i;
      mac_q  <= in_mac_i;
    end
    if (cmd_i.step_lookup && pend_q && key_eq && !hit_q) begin
      hmac_q <= rdata_q[EW-1:IP_W];
    end
  end

  // Advance pointers, count and per-item flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q   <= '0;
      wr_idx_q   <= '0;
      lim_q      <= '0;
      count_q    <= '0;
      pend_q     <= 1'b0;
      hit_q      <= 1'b0;
      replaced_q <= 1'b0;
      evicted_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        rd_idx_q   <= '0;
        wr_idx_q   <= '0;
        lim_q      <= count_q;
        pend_q     <= 1'b0;
        hit_q      <= 1'b0;
        replaced_q <= 1'b0;
        evicted_q  <= 1'b0;
      end else if (cmd_i.start_shift) begin
        rd_idx_q  <= CW'(1);
        wr_idx_q  <= '0;
        lim_q     <= wr_idx_q;
        pend_q    <= 1'b0;
        evicted_q <= 1'b1;
      end else begin
        pend_q <= issue;
        if (issue) begin
          rd_idx_q <= rd_idx_q + CW'(1);
        end
        if (copy_wr) begin
          wr_idx_q <= wr_idx_q + CW'(1);
        end
        if (cmd_i.step_copy && pend_q && !cmd_i.keep_all && key_eq) begin
          replaced_q <= 1'b1;
        end
        if (cmd_i.step_lookup && pend_q && key_eq) begin
          hit_q <= 1'b1;
        end
        if (cmd_i.append) begin
          count_q <= wr_idx_q + CW'(1);
        end
      end
    end
  end

  // Output register: holds a result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.post_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.post_result) begin
      if (kind_q == KIND_LOOKUP) begin
        out_hit_q   <= hit_q;
        out_mac_q   <= hit_q ? hmac_q : '0;
        out_send_q  <= !hit_q;
        out_repl_q  <= 1'b0;
        out_evict_q <= 1'b0;
      end else begin
        out_hit_q   <= 1'b0;
        out_mac_q   <= '0;
        out_send_q  <= 1'b0;
        out_repl_q  <= replaced_q;
        out_evict_q <= evicted_q;
      end
    end
  end

  assign sts_o.match     = pend_q && key_eq;
  assign sts_o.scan_done = !pend_q && (rd_idx_q >= lim_q);
  assign sts_o.full      = (wr_idx_q == DEPTH_C);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o        = out_valid_q;
  assign out_hit_o          = out_hit_q;
  assign out_found_mac_o    = out_mac_q;
  assign out_send_request_o = out_send_q;
  assign out_replaced_o     = out_repl_q;
  assign out_evicted_o      = out_evict_q;

  // The entry count never passes the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= DEPTH_C)
    else $error("entry count beyond table depth");

  // A copy pass never writes ahead of the slot it reads
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_i.step_copy |-> wr_idx_q <= rd_idx_q)
    else $error("compaction write passed read pointer");

  // Append leaves the count one above the write slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_i.append |=> count_q == $past(wr_idx_q) + CW'(1))
    else $error("entry count not updated on append");

  // A replace frees a slot and so never evicts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_q |-> !(out_repl_q && out_evict_q))
    else $error("replaced and evicted both set");

  // A lookup result is either a hit or a request, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_q |-> !(out_hit_q && out_send_q))
    else $error("hit and send_request both set");

endmodule

// File: dv/arp_cache_lookup_update_chk.sv
// Scoreboard for the ARP cache: watches both stream channels, predicts each result
// from its own copy of the table, and compares. Depends on arpc_pkg.
module arp_cache_lookup_update_chk
  import arpc_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // [31:0] ip_address, [79:32] mac_address
  input  logic        s_axis_tuser,   // [0] kind
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,   // [0] hit, [48:1] found_mac, [49] send_request,
                                      // [50] replaced, [51] evicted, [55:52] zero
  output int          err_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        hit;
    logic [47:0] found_mac;
    logic        send_request;
    logic        replaced;
    logic        evicted;
    logic [3:0]  pad;
  } arp_result_t;

  // Shadow table, oldest entry in slot 0
  logic [IP_W-1:0]  cache_ip  [TABLE_DEPTH];
  logic [MAC_W-1:0] cache_mac [TABLE_DEPTH];
  int unsigned      cache_fill;

  arp_result_t expected_results[$];
  int          fail_count = 0;
  int unsigned result_index = 0;

  assign err_count_o = fail_count;

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("[%0t] result %0d: %s got 0x%0h expected 0x%0h",
             $realtime, result_index, what, got, want);
    fail_count++;
  endtask

  // Remove one slot and close the gap toward the oldest end
  function automatic void drop_entry(input int unsigned pos);
    for (int unsigned j = pos; j + 1 < cache_fill; j++) begin
      cache_ip[j]  = cache_ip[j+1];
      cache_mac[j] = cache_mac[j+1];
    end
    cache_fill--;
  endfunction

  // Apply one transaction to the shadow table and return the result it must cause
  function automatic arp_result_t predict_cache_access(input logic kind,
                                                       input logic [IP_W-1:0] ip,
                                                       input logic [MAC_W-1:0] mac);
    arp_result_t res;
    int unsigned i;
    res = '0;
    if (kind == KIND_LOOKUP) begin
      for (i = 0; i < cache_fill; i++) begin
        if (cache_ip[i] == ip) begin
          res.hit       = 1'b1;
          res.found_mac = cache_mac[i];
          return res;
        end
      end
      res.send_request = 1'b1;
      return res;
    end
    i = 0;
    while (i < cache_fill) begin
      if (cache_ip[i] == ip) begin
        drop_entry(i);
        res.replaced = 1'b1;
      end else begin
        i++;
      end
    end
    // Full table with nothing removed: drop the oldest
    if (cache_fill >= TABLE_DEPTH) begin
      drop_entry(0);
      res.evicted = 1'b1;
    end
    cache_ip[cache_fill]  = ip;
    cache_mac[cache_fill] = mac;
    cache_fill++;
    return res;
  endfunction

  function automatic arp_result_t unpack_result(input logic [55:0] data);
    arp_result_t res;
    res.hit          = data[0];
    res.found_mac    = data[48:1];
    res.send_request = data[49];
    res.replaced     = data[50];
    res.evicted      = data[51];
    res.pad          = data[55:52];
    return res;
  endfunction

  task automatic check_result(input arp_result_t got);
    arp_result_t want;
    if (expected_results.size() == 0) begin
      $display("[%0t] result %0d: no transaction is waiting for it", $realtime, result_index);
      fail_count++;
    end else begin
      want = expected_results.pop_front();
      if (got.hit !== want.hit)
        report_mismatch("hit", 48'(got.hit), 48'(want.hit));
      if (got.found_mac !== want.found_mac)
        report_mismatch("found_mac", got.found_mac, want.found_mac);
      if (got.send_request !== want.send_request)
        report_mismatch("send_request", 48'(got.send_request), 48'(want.send_request));
      if (got.replaced !== want.replaced)
        report_mismatch("replaced", 48'(got.replaced), 48'(want.replaced));
      if (got.evicted !== want.evicted)
        report_mismatch("evicted", 48'(got.evicted), 48'(want.evicted));
      if (got.pad !== want.pad)
        report_mismatch("padding", 48'(got.pad), 48'(want.pad));
    end
    result_index++;
  endtask

  // Retire results first: a result never belongs to a transaction of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_fill = 0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        check_result(unpack_result(m_axis_tdata));
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(predict_cache_access(s_axis_tuser,
                                                        s_axis_tdata[31:0],
                                                        s_axis_tdata[79:32]));
      pending_o <= expected_results.size();
    end
  end

endmodule

// File: dv/arp_cache_lookup_update_tb.sv
// Top of the ARP cache testbench: clock, reset, lookup/update stimulus, result sink.
// Depends on arpc_pkg, arp_cache_lookup_update and arp_cache_lookup_update_chk.
module arp_cache_lookup_update_tb
  import arpc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = 16;
  localparam int          RANDOM_ITEMS = 1000;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 64;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        s_axis_tuser = KIND_LOOKUP;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  int err_count;
  int pending;

  // No-idle stretches and the one long sink hold-off
  logic calm = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  logic [31:0] ip_pool [32];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  arp_cache_lookup_update #(
    .TABLE_DEPTH (DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  arp_cache_lookup_update_chk #(
    .TABLE_DEPTH (DEPTH)
  ) u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .err_count_o   (err_count),
    .pending_o     (pending)
  );

  function automatic int idle_cycles();
    return calm ? 0 : int'($urandom_range(0, 15));
  endfunction

  function automatic logic [47:0] random_mac();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[47:0];
  endfunction

  // Offer one transaction after a random gap and hold it until accepted
  task automatic push_item(input logic kind, input logic [31:0] ip, input logic [47:0] mac);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {mac, ip};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Result sink: random stalls, one long hold-off on request
  initial begin
    int gap;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      gap = idle_cycles();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // Stimulus and verdict
  initial begin
    logic        kind;
    logic [31:0] ip;
    int          pool_size;

    foreach (ip_pool[i]) ip_pool[i] = $urandom();
    ip_pool[0] = 32'h0000_0000;
    ip_pool[1] = 32'hFFFF_FFFF;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table, extreme keys and MACs, hit, replace
    push_item(KIND_LOOKUP, 32'h0000_0000, 48'h0);
    push_item(KIND_UPDATE, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
    push_item(KIND_UPDATE, 32'hFFFF_FFFF, 48'h0);
    push_item(KIND_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    push_item(KIND_LOOKUP, 32'h0000_0000, 48'h0);
    push_item(KIND_UPDATE, 32'h0000_0000, 48'h5555_AAAA_5555);
    push_item(KIND_LOOKUP, 32'h0000_0000, 48'h0);
    // Fill the table; the last update drops the oldest key
    for (int i = 0; i < 15; i++)
      push_item(KIND_UPDATE, 32'h0A00_0001 + i, random_mac());
    push_item(KIND_LOOKUP, 32'hFFFF_FFFF, 48'h0);

    // Random traffic in phases of varying key-pool size
    pool_size = 12;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 80 == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 3))
          0: pool_size = 4;
          1: pool_size = 12;
          2: pool_size = 20;
          default: pool_size = 32;
        endcase
      end
      if (n == RANDOM_ITEMS / 2) hold_req = 1'b1;
      kind = $urandom_range(0, 1) ? KIND_UPDATE : KIND_LOOKUP;
      if ($urandom_range(0, 7) == 0)
        ip = $urandom();
      else
        ip = ip_pool[$urandom_range(0, pool_size - 1)];
      push_item(kind, ip, random_mac());
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then allow for any stray result
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/arpc_pkg.sv
hw/rtl/arpc_ctrl.sv
hw/rtl/arpc_dp.sv
hw/rtl/arp_cache_lookup_update.sv
dv/arp_cache_lookup_update_chk.sv
dv/arp_cache_lookup_update_tb.sv
